/* sv/scbpa_pkg.sv */
// ----------------------------------------------------------------------------
// scbpa_pkg: shared types and constants of the size class block pool allocator
// Request and result layouts, status and op codes, reset values of the
// block size registers and default slot counts.
// ----------------------------------------------------------------------------
package scbpa_pkg;

    localparam int NUM_CLASSES = 5;
    localparam int MAX_SLOTS   = 32;
    localparam int CLASS_W     = 3;
    localparam int SLOT_W      = 5;
    localparam int COUNT_W     = 6;
    localparam int SIZE_W      = 9;
    localparam int REQ_BYTES_W = 16;
    localparam int FAIL_W      = 16;
    localparam int TOTAL_W     = 16;
    localparam int CFG_IDX_W   = 3;

    // default slot counts per class
    localparam int DEF_CLASS0_SLOTS = 32;
    localparam int DEF_CLASS1_SLOTS = 32;
    localparam int DEF_CLASS2_SLOTS = 32;
    localparam int DEF_CLASS3_SLOTS = 16;
    localparam int DEF_CLASS4_SLOTS = 8;

    // block size register reset values
    localparam logic [SIZE_W-1:0] BLOCK_BYTES_RST [NUM_CLASSES] = '{
        9'd16, 9'd32, 9'd64, 9'd128, 9'd256
    };

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_SIZE    = 3'd1,
        ST_EXHAUSTED   = 3'd2,
        ST_DOUBLE_FREE = 3'd3,
        ST_BAD_HANDLE  = 3'd4
    } status_t;

    typedef struct packed {
        op_t                    op;
        logic [REQ_BYTES_W-1:0] request_bytes;
        logic [CLASS_W-1:0]     free_class;
        logic [SLOT_W-1:0]      free_slot;
    } req_t;

    typedef struct packed {
        status_t                status;
        logic [CLASS_W-1:0]     block_class;
        logic [SLOT_W-1:0]      block_slot;
        logic [COUNT_W-1:0]     class_live_blocks;
        logic [COUNT_W-1:0]     class_peak_blocks;
        logic [FAIL_W-1:0]      class_fail_count;
        logic [TOTAL_W-1:0]     bytes_in_use;
    } result_t;

endpackage

/* sv/size_class_block_pool_allocator.sv */
// Path: a request is taken into the input register, evaluated, and its result is
// written into the result register, which drives the result ports.
// Throughput: one request per cycle; busy never rises, and each request does at
// most one stack pop or push. The receiver cannot stall.
// Reset (rst_n low, async): stacks refilled with highest slot on top, all slots
// free, counters and byte total cleared, block sizes back to 16/32/64/128/256.
// ----------------------------------------------------------------------------
// size_class_block_pool_allocator: five-class fixed block pool allocator
// Allocate picks the smallest fitting class and pops a free slot; free checks
// the handle and pushes the slot back. Each request yields one result.
// ----------------------------------------------------------------------------
module size_class_block_pool_allocator #(
    parameter int CLASS0_SLOTS = scbpa_pkg::DEF_CLASS0_SLOTS,
    parameter int CLASS1_SLOTS = scbpa_pkg::DEF_CLASS1_SLOTS,
    parameter int CLASS2_SLOTS = scbpa_pkg::DEF_CLASS2_SLOTS,
    parameter int CLASS3_SLOTS = scbpa_pkg::DEF_CLASS3_SLOTS,
    parameter int CLASS4_SLOTS = scbpa_pkg::DEF_CLASS4_SLOTS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // request channel
    input  logic                             start,
    output logic                             busy,
    input  scbpa_pkg::req_t                  req,
    // result channel
    output logic                             done,
    output scbpa_pkg::result_t               result,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [scbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [scbpa_pkg::SIZE_W-1:0]     cfg_data
);

    localparam int NC  = scbpa_pkg::NUM_CLASSES;
    localparam int MS  = scbpa_pkg::MAX_SLOTS;
    localparam int CW  = scbpa_pkg::CLASS_W;
    localparam int SW  = scbpa_pkg::SLOT_W;
    localparam int KW  = scbpa_pkg::COUNT_W;
    localparam int BW  = scbpa_pkg::SIZE_W;
    localparam int RW  = scbpa_pkg::REQ_BYTES_W;
    localparam int FW  = scbpa_pkg::FAIL_W;
    localparam int TW  = scbpa_pkg::TOTAL_W;

    // slot count of each class, as a 6-bit count
    localparam logic [KW-1:0] SLOTS [NC] = '{
        KW'(CLASS0_SLOTS), KW'(CLASS1_SLOTS), KW'(CLASS2_SLOTS),
        KW'(CLASS3_SLOTS), KW'(CLASS4_SLOTS)
    };
    localparam logic [KW-1:0] STACK_FULL = KW'(MS);
    localparam logic [FW-1:0] FAIL_MAX   = {FW{1'b1}};
    localparam logic [TW-1:0] TOTAL_MAX  = {TW{1'b1}};
    localparam logic [CW-1:0] LAST_CLASS = CW'(NC - 1);

    // the block never holds off requests or config writes
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Block size registers
    // ------------------------------------------------------------------
    logic [BW-1:0] bb_reg [NC];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NC; c++)
            begin
                bb_reg[c] <= scbpa_pkg::BLOCK_BYTES_RST[c];
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            for (int c = 0; c < NC; c++)
            begin
                if (cfg_index == CW'(c))
                begin
                    bb_reg[c] <= cfg_data;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic            in_v_reg;
    scbpa_pkg::req_t in_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_reg <= req;
        end
    end

    // ------------------------------------------------------------------
    // Per-class state
    // ------------------------------------------------------------------
    logic [KW-1:0]    top_reg  [NC];
    logic [KW-1:0]    live_reg [NC];
    logic [KW-1:0]    peak_reg [NC];
    logic [FW-1:0]    fail_reg [NC];
    logic [MS-1:0]    busy_reg [NC];
    logic [TW-1:0]    used_reg;

    logic [SW-1:0]    pop_slot  [NC];   // slot on top of each stack
    logic [NC-1:0]    push_en;          // stack write strobe per class
    logic [SW-1:0]    push_slot;

    // each class's free stack: one write and one read port
    for (genvar g = 0; g < NC; g++)
    begin : gen_stack
        logic [SW-1:0] stack_reg [MS];

        assign pop_slot[g] = stack_reg[SW'(top_reg[g] - KW'(1))];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                for (int i = 0; i < MS; i++)
                begin
                    stack_reg[i] <= SW'(i);
                end
            end
            else if (push_en[g])
            begin
                stack_reg[top_reg[g][SW-1:0]] <= push_slot;
            end
        end
    end

    // ------------------------------------------------------------------
    // Evaluate: class select, checks, counter updates
    // ------------------------------------------------------------------
    logic               is_alloc;
    logic [CW-1:0]      fit_cls;
    logic               fit_any;
    logic               size_bad;
    logic [CW-1:0]      act_cls;
    logic               cls_ok;
    logic [KW-1:0]      top_a;
    logic [KW-1:0]      live_a;
    logic [KW-1:0]      peak_a;
    logic [FW-1:0]      fail_a;
    logic [BW-1:0]      bb_a;
    logic               busy_a;
    logic [SW-1:0]      pop_a;

    scbpa_pkg::status_t st;
    logic [CW-1:0]      res_cls;
    logic [SW-1:0]      res_slot;
    logic               has_cls;
    logic               do_pop;
    logic               do_push;
    logic               do_fail;

    logic [KW-1:0]      top_next;
    logic [KW-1:0]      live_next;
    logic [KW-1:0]      peak_next;
    logic [FW-1:0]      fail_next;
    logic [TW:0]        used_sum;
    logic [TW-1:0]      used_next;

    assign is_alloc = (in_reg.op == scbpa_pkg::OP_ALLOC);

    // smallest class whose block size covers the request
    always_comb
    begin
        fit_cls = '0;
        fit_any = 1'b0;
        for (int c = NC - 1; c >= 0; c--)
        begin
            if ({{(RW-BW){1'b0}}, bb_reg[c]} >= in_reg.request_bytes)
            begin
                fit_cls = CW'(c);
                fit_any = 1'b1;
            end
        end
    end

    assign size_bad = (in_reg.request_bytes == '0)
                   || (in_reg.request_bytes > {{(RW-BW){1'b0}}, bb_reg[LAST_CLASS]})
                   || !fit_any;

    assign act_cls = is_alloc ? fit_cls : in_reg.free_class;
    assign cls_ok  = (act_cls <= LAST_CLASS);

    // one read of the selected class's state
    always_comb
    begin
        top_a  = '0;
        live_a = '0;
        peak_a = '0;
        fail_a = '0;
        bb_a   = '0;
        busy_a = 1'b0;
        pop_a  = '0;
        if (cls_ok)
        begin
            top_a  = top_reg[act_cls];
            live_a = live_reg[act_cls];
            peak_a = peak_reg[act_cls];
            fail_a = fail_reg[act_cls];
            bb_a   = bb_reg[act_cls];
            busy_a = busy_reg[act_cls][in_reg.free_slot];
            pop_a  = pop_slot[act_cls];
        end
    end

    // request decode
    always_comb
    begin
        st       = scbpa_pkg::ST_OK;
        res_cls  = act_cls;
        res_slot = in_reg.free_slot;
        has_cls  = 1'b1;
        do_pop   = 1'b0;
        do_push  = 1'b0;
        do_fail  = 1'b0;
        if (is_alloc)
        begin
            if (size_bad)
            begin
                st       = scbpa_pkg::ST_BAD_SIZE;
                res_cls  = '0;
                res_slot = '0;
                has_cls  = 1'b0;
            end
            else if (top_a == '0)
            begin
                st       = scbpa_pkg::ST_EXHAUSTED;
                res_slot = '0;
                do_fail  = in_v_reg;
            end
            else
            begin
                res_slot = pop_a;
                do_pop   = in_v_reg;
            end
        end
        else
        begin
            if (!cls_ok)
            begin
                st      = scbpa_pkg::ST_BAD_HANDLE;
                has_cls = 1'b0;
            end
            else if ({1'b0, in_reg.free_slot} >= SLOTS[act_cls])
            begin
                st = scbpa_pkg::ST_BAD_HANDLE;
            end
            else if (!busy_a)
            begin
                st = scbpa_pkg::ST_DOUBLE_FREE;
            end
            else
            begin
                do_push = in_v_reg;
            end
        end
    end

    // counter next values for the selected class
    always_comb
    begin
        top_next  = top_a;
        live_next = live_a;
        fail_next = fail_a;
        used_sum  = {1'b0, used_reg} + {{(TW+1-BW){1'b0}}, bb_a};
        used_next = used_reg;
        if (do_pop)
        begin
            top_next  = top_a - KW'(1);
            if (live_a < STACK_FULL)
            begin
                live_next = live_a + KW'(1);
            end
            used_next = used_sum[TW] ? TOTAL_MAX : used_sum[TW-1:0];
        end
        if (do_push)
        begin
            if (top_a < STACK_FULL)
            begin
                top_next = top_a + KW'(1);
            end
            if (live_a != '0)
            begin
                live_next = live_a - KW'(1);
            end
            if (used_reg >= {{(TW-BW){1'b0}}, bb_a})
            begin
                used_next = used_reg - {{(TW-BW){1'b0}}, bb_a};
            end
        end
        if (do_fail && (fail_a != FAIL_MAX))
        begin
            fail_next = fail_a + FW'(1);
        end
        peak_next = (live_next > peak_a) ? live_next : peak_a;
    end

    // stack write: only when the stack has room
    always_comb
    begin
        push_en = '0;
        if (do_push && (top_a < STACK_FULL))
        begin
            push_en[act_cls] = 1'b1;
        end
    end
    assign push_slot = in_reg.free_slot;

    // state update, written back to the selected class only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NC; c++)
            begin
                top_reg[c]  <= SLOTS[c];
                live_reg[c] <= '0;
                peak_reg[c] <= '0;
                fail_reg[c] <= '0;
                busy_reg[c] <= '0;
            end
            used_reg <= '0;
        end
        else
        begin
            if (do_pop || do_push || do_fail)
            begin
                top_reg[act_cls]  <= top_next;
                live_reg[act_cls] <= live_next;
                peak_reg[act_cls] <= peak_next;
                fail_reg[act_cls] <= fail_next;
                used_reg          <= used_next;
            end
            if (do_pop)
            begin
                busy_reg[act_cls][pop_a] <= 1'b1;
            end
            if (do_push)
            begin
                busy_reg[act_cls][in_reg.free_slot] <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic               done_reg;
    scbpa_pkg::result_t res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_v_reg)
        begin
            res_reg.status            <= st;
            res_reg.block_class       <= res_cls;
            res_reg.block_slot        <= res_slot;
            res_reg.class_live_blocks <= has_cls ? live_next : '0;
            res_reg.class_peak_blocks <= has_cls ? peak_next : '0;
            res_reg.class_fail_count  <= has_cls ? fail_next : '0;
            res_reg.bytes_in_use      <= used_next;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("request without result two cycles later");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_v_reg))
        else $error("result without a request");

    a_live_le_peak: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.class_live_blocks <= result.class_peak_blocks))
        else $error("live count above peak");

    a_exhausted_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == scbpa_pkg::ST_EXHAUSTED)) |-> (result.block_slot == '0))
        else $error("exhausted result carries a slot");

    a_bad_size_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == scbpa_pkg::ST_BAD_SIZE))
        |-> ((result.block_class == '0) && (result.class_fail_count == '0)))
        else $error("bad size result carries class data");

endmodule
